### hdl/sha256_pkg.sv
// sha256_pkg: shared types and constants of the sha-256 hash engine
// transaction structs, sequencer states, core command struct, round and initial constants
// no dependencies
package sha256_pkg;

  // input transaction: one big-endian message word
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } sha256_in_t;

  // output transaction: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } sha256_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_FILL,
    S_LENLO,
    S_COMP,
    S_ADD,
    S_OUT
  } sha256_state_e;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic        push;
    logic [31:0] push_word;
    logic        load_vars;
    logic        round_en;
    logic [5:0]  round_idx;
    logic        add_hash;
    logic        restart;
  } sha256_cmd_t;

  // digest readout request from the sequencer
  typedef struct packed {
    logic       emit;
    logic [2:0] emit_idx;
  } sha256_emit_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] PAD_MARK = 32'h80000000;

endpackage

### hdl/sha256_core.sv
// sha256_core: hash state, working variables, schedule shift window and the shared round unit
// one compression round per enabled cycle under commands from sha256_ctrl
// depends on sha256_pkg
module sha256_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::sha256_cmd_t cmd_i,
  output logic [7:0][31:0]       hash_o
);

  logic [7:0][31:0]  hash_q, hash_d;
  logic [7:0][31:0]  vars_q, vars_d;
  logic [15:0][31:0] win_q, win_d;

  logic [31:0] sched_new, w_t, t1, t2;
  logic [31:0] ea, eb, ec, ed, ee, ef, eg, eh;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // message schedule: window holds w[t..t+15], oldest at index 0
  assign w_t       = win_q[0];
  assign sched_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  // round unit on a..h
  assign ea = vars_q[0];
  assign eb = vars_q[1];
  assign ec = vars_q[2];
  assign ed = vars_q[3];
  assign ee = vars_q[4];
  assign ef = vars_q[5];
  assign eg = vars_q[6];
  assign eh = vars_q[7];
  assign t1 = eh + big_sigma1(ee) + ((ee & ef) ^ (~ee & eg))
            + sha256_pkg::ROUND_K[cmd_i.round_idx] + w_t;
  assign t2 = big_sigma0(ea) + ((ea & eb) ^ (ea & ec) ^ (eb & ec));

  // next window: shift in a message word or a scheduled word
  always_comb begin
    win_d = win_q;
    if (cmd_i.push) begin
      win_d = {cmd_i.push_word, win_q[15:1]};
    end else if (cmd_i.round_en) begin
      win_d = {sched_new, win_q[15:1]};
    end
  end

  // next hash state and working variables
  always_comb begin
    hash_d = hash_q;
    vars_d = vars_q;
    if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = sha256_pkg::INIT_H[i];
      end
      vars_d = '0;
    end else if (cmd_i.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + vars_q[i];
      end
    end else if (cmd_i.load_vars) begin
      vars_d = hash_q;
    end else if (cmd_i.round_en) begin
      vars_d[0] = t1 + t2;
      vars_d[1] = ea;
      vars_d[2] = eb;
      vars_d[3] = ec;
      vars_d[4] = ed + t1;
      vars_d[5] = ee;
      vars_d[6] = ef;
      vars_d[7] = eg;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha256_pkg::INIT_H[i];
      end
      vars_q <= '0;
    end else begin
      hash_q <= hash_d;
      vars_q <= vars_d;
    end
  end

  // schedule window is written before it is read
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign hash_o = hash_q;

`ifndef SYNTHESIS
  // a restart always lands on the initial hash values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.restart |=> (hash_q[0] == sha256_pkg::INIT_H[0] && hash_q[7] == sha256_pkg::INIT_H[7]))
    else $error("hash state not reinitialized after restart");
  // the window never takes a message word and a scheduled word at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.round_en))
    else $error("push and round in the same cycle");
  // working variables are loaded only outside a round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_vars |-> !cmd_i.round_en && !cmd_i.add_hash)
    else $error("variable load collides with round or add");
`endif

endmodule

### hdl/sha256_ctrl.sv
// sha256_ctrl: sequencer of the hash engine
// word gathering, padding, bit length, round counter and digest readout
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sha256_pkg::sha256_in_t   in_data_i,
  input  logic                     out_free_i,
  output sha256_pkg::sha256_cmd_t  cmd_o,
  output sha256_pkg::sha256_emit_t emit_o
);

  sha256_pkg::sha256_state_e state_q, state_d;
  sha256_pkg::sha256_state_e ret_q, ret_d;
  sha256_pkg::sha256_state_e after_push;

  logic [3:0]  word_idx_q, word_idx_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic [63:0] bit_len_q, bit_len_d;

  logic        in_accept;
  logic [2:0]  count_eff;
  logic [31:0] last_word;

  assign in_stall_o = (state_q != sha256_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // effective byte count: full word unless a short last word
  assign count_eff = (!in_data_i.last || in_data_i.byte_count > 3'd4) ? 3'd4
                                                                      : in_data_i.byte_count;

  // short last word: keep leading bytes and place the 0x80 byte after them
  always_comb begin
    unique case (count_eff[1:0])
      2'd0: last_word = sha256_pkg::PAD_MARK;
      2'd1: last_word = {in_data_i.data_word[31:24], 24'h800000};
      2'd2: last_word = {in_data_i.data_word[31:16], 16'h8000};
      default: last_word = {in_data_i.data_word[31:8], 8'h80};
    endcase
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    word_idx_d = word_idx_q;
    round_d    = round_q;
    out_idx_d  = out_idx_q;
    bit_len_d  = bit_len_q;
    after_push = state_q;
    cmd_o      = '0;
    emit_o     = '0;
    cmd_o.round_idx = round_q;

    unique case (state_q)
      sha256_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_o.push = 1'b1;
          bit_len_d  = bit_len_q + {58'd0, count_eff, 3'b000};
          if (!in_data_i.last) begin
            cmd_o.push_word = in_data_i.data_word;
            after_push      = sha256_pkg::S_IDLE;
          end else if (count_eff[2]) begin
            cmd_o.push_word = in_data_i.data_word;
            after_push      = sha256_pkg::S_MARK;
          end else begin
            cmd_o.push_word = last_word;
            after_push      = sha256_pkg::S_FILL;
          end
        end
      end
      sha256_pkg::S_MARK: begin
        cmd_o.push      = 1'b1;
        cmd_o.push_word = sha256_pkg::PAD_MARK;
        after_push      = sha256_pkg::S_FILL;
      end
      sha256_pkg::S_FILL: begin
        cmd_o.push = 1'b1;
        if (word_idx_q == 4'd14) begin
          cmd_o.push_word = bit_len_q[63:32];
          after_push      = sha256_pkg::S_LENLO;
        end else begin
          cmd_o.push_word = '0;
          after_push      = sha256_pkg::S_FILL;
        end
      end
      sha256_pkg::S_LENLO: begin
        cmd_o.push      = 1'b1;
        cmd_o.push_word = bit_len_q[31:0];
        after_push      = sha256_pkg::S_OUT;
      end
      sha256_pkg::S_COMP: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = sha256_pkg::S_ADD;
        end
      end
      sha256_pkg::S_ADD: begin
        cmd_o.add_hash = 1'b1;
        state_d        = ret_q;
      end
      sha256_pkg::S_OUT: begin
        if (out_free_i) begin
          emit_o.emit     = 1'b1;
          emit_o.emit_idx = out_idx_q;
          out_idx_d       = out_idx_q + 3'd1;
          if (out_idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            bit_len_d     = '0;
            word_idx_d    = '0;
            state_d       = sha256_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = sha256_pkg::S_IDLE;
      end
    endcase

    // a push that fills the block starts a compression first
    if (cmd_o.push) begin
      word_idx_d = word_idx_q + 4'd1;
      if (word_idx_q == 4'd15) begin
        cmd_o.load_vars = 1'b1;
        ret_d           = after_push;
        state_d         = sha256_pkg::S_COMP;
      end else begin
        state_d = after_push;
      end
    end
  end

  // state register and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha256_pkg::S_IDLE;
      ret_q      <= sha256_pkg::S_IDLE;
      word_idx_q <= '0;
      round_q    <= '0;
      out_idx_q  <= '0;
      bit_len_q  <= '0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      word_idx_q <= word_idx_d;
      round_q    <= round_d;
      out_idx_q  <= out_idx_d;
      bit_len_q  <= bit_len_d;
    end
  end

`ifndef SYNTHESIS
  // the last round always hands over to the hash update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::S_COMP && round_q == 6'd63) |=> state_q == sha256_pkg::S_ADD)
    else $error("compression did not end in hash update");
  // the low length word always closes a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha256_pkg::S_LENLO |-> word_idx_q == 4'd15)
    else $error("length word misplaced in block");
  // after the eighth digest word the message state is cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.emit && emit_o.emit_idx == 3'd7) |=> (bit_len_q == '0 && word_idx_q == '0))
    else $error("message state not cleared after digest");
`endif

endmodule

### hdl/sha256_hash_engine.sv
// sha256_hash_engine: top level of the streaming sha-256 hash engine
// ties sha256_ctrl and sha256_core together and holds the digest output register
// depends on sha256_pkg, sha256_ctrl, sha256_core
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (data_word, byte_count, last)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (digest_word, digest_last)
//
// a word that does not finish a block is pushed into the window; the sixteenth word of a block
// also starts 64 rounds of the shared round unit and one hash update, with the input stalled
// a last word adds its padding words (up to 18) plus one or two compressions,
// then the eight digest words are handed out through the output register
// reset clears control, hash state and length at once; no clearing pass
// the output register holds a digest word under out_stall_i; the readout waits while it is full and stalled
module sha256_hash_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sha256_pkg::sha256_in_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sha256_pkg::sha256_out_t out_data_o
);

  sha256_pkg::sha256_cmd_t  cmd;
  sha256_pkg::sha256_emit_t emit;
  logic [7:0][31:0]         hash;
  logic                     out_free;
  logic                     out_valid_q, out_valid_d;
  sha256_pkg::sha256_out_t  out_data_q, out_data_d;

  sha256_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  sha256_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .hash_o (hash)
  );

  // output register: free when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit.emit) begin
      out_valid_d            = 1'b1;
      out_data_d.digest_word = hash[emit.emit_idx];
      out_data_d.digest_last = (emit.emit_idx == 3'd7);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a digest word is never loaded over one that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> out_free)
    else $error("digest word overwrites a pending transaction");
  // no input is taken while the digest is being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> in_stall_o)
    else $error("input accepted during digest readout");
  // the final digest word is followed by an idle engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.emit && emit.emit_idx == 3'd7) |=> !in_stall_o)
    else $error("engine not idle after digest");
`endif

endmodule

### tb/sha256_hash_engine_test.sv
// sha256_hash_engine_test: self-checking testbench of the streaming sha-256 hash engine
// a queue-fed driver with a digest predictor and a checking monitor with its own stall pattern
// depends on sha256_pkg and sha256_hash_engine
`timescale 1ns / 1ps

module sha256_hash_engine_test;

  // word queued for the driver, optionally held back until all digests are in
  typedef struct {
    sha256_pkg::sha256_in_t item;
    bit                     drain;
  } pend_word_t;

  // receiver stall behavior
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  localparam int          RANDOM_WORDS = 330;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          TAIL_CYCLES  = 200;
  localparam int          REPORT_MAX   = 10;
  localparam logic [31:0] PAD_BYTE     = 32'h00000080;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  sha256_pkg::sha256_in_t  in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  sha256_pkg::sha256_out_t out_data;

  sha256_hash_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // predictor state: chaining value, schedule window, message length
  logic [31:0] chain_h [8];
  logic [31:0] sched_win [16];
  logic [63:0] msg_bits;
  logic [3:0]  win_pos;

  sha256_pkg::sha256_out_t digest_expect [$];
  pend_word_t              word_queue [$];
  int                      fail_count = 0;
  int                      word_total = 0;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    msg_bits = '0;
    win_pos  = '0;
  endtask

  // 64 rounds over the window, folded into the chaining value
  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] w, s0, s1, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_win[t];
      end else begin
        x2  = sched_win[(t - 2) & 15];
        x15 = sched_win[(t - 15) & 15];
        s1  = rotr32(x2, 17) ^ rotr32(x2, 19) ^ (x2 >> 10);
        s0  = rotr32(x15, 7) ^ rotr32(x15, 18) ^ (x15 >> 3);
        w   = s1 + sched_win[(t - 7) & 15] + s0 + sched_win[t & 15];
        sched_win[t & 15] = w;
      end
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w;
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic absorb_word(input logic [31:0] w);
    sched_win[win_pos] = w;
    win_pos = win_pos + 4'd1;
    if (win_pos == 4'd0) compress_block();
  endtask

  // update the digest prediction with one accepted input transaction
  task automatic predict_word(input sha256_pkg::sha256_in_t it);
    int                      nbytes;
    logic [31:0]             keep;
    sha256_pkg::sha256_out_t res;
    nbytes = it.byte_count;
    if (nbytes > 4 || !it.last) nbytes = 4;
    msg_bits = msg_bits + 64'(8 * nbytes);
    if (!it.last) begin
      absorb_word(it.data_word);
    end else begin
      if (nbytes < 4) begin
        keep = (nbytes == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nbytes));
        absorb_word((it.data_word & keep) | (PAD_BYTE << (8 * (3 - nbytes))));
      end else begin
        absorb_word(it.data_word);
        absorb_word(PAD_BYTE << 24);
      end
      while (win_pos != 4'd14) absorb_word(32'h0);
      absorb_word(msg_bits[63:32]);
      absorb_word(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        res.digest_word = chain_h[k];
        res.digest_last = (k == 7);
        digest_expect.push_back(res);
      end
      restart_hash();
    end
  endtask

  task automatic add_word(input logic [31:0] data, input int cnt, input bit is_last,
                          input bit drain);
    pend_word_t p;
    p.item.data_word  = data;
    p.item.byte_count = 3'(cnt);
    p.item.last       = is_last;
    p.drain           = drain;
    word_queue.push_back(p);
    word_total++;
  endtask

  // random message: body words mostly full, odd counts as noise
  task automatic add_message(input int nwords, input bit drain);
    int cnt;
    for (int i = 0; i < nwords - 1; i++) begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
      add_word($urandom, cnt, 1'b0, drain && i == 0);
    end
    add_word($urandom, $urandom_range(0, 7), 1'b1, drain && nwords == 1);
  endtask

  // stimulus and end of run
  initial begin
    int nwords;
    bit drain;
    bit forced_drain;
    restart_hash();
    // empty message with garbage in the unused bytes
    add_word(32'hffffffff, 0, 1'b1, 1'b0);
    // "abc" with trailing garbage that must be masked
    add_word(32'h616263ff, 3, 1'b1, 1'b0);
    add_word(32'hffffffff, 1, 1'b1, 1'b0);
    add_word(32'hffffffff, 2, 1'b1, 1'b0);
    add_word(32'hffffffff, 7, 1'b1, 1'b0);
    add_word(32'h00000000, 4, 1'b1, 1'b0);
    // short counts on body words are taken as full words
    add_word(32'h12345678, 0, 1'b0, 1'b0);
    add_word(32'h9abcdef0, 0, 1'b1, 1'b0);
    add_word(32'hdeadbeef, 5, 1'b0, 1'b0);
    add_word(32'hcafef00d, 3, 1'b1, 1'b0);
    // 56-byte message: padding spills into an extra block
    for (int i = 0; i < 13; i++) add_word($urandom, 4, 1'b0, 1'b0);
    add_word(32'hffffffff, 4, 1'b1, 1'b0);

    forced_drain = 1'b0;
    while (word_total < RANDOM_WORDS) begin
      nwords = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20) : $urandom_range(21, 48);
      drain  = ($urandom_range(0, 9) == 0);
      if (!forced_drain && word_total > 200) begin
        drain        = 1'b1;
        forced_drain = 1'b1;
      end
      add_message(nwords, drain);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (digest_expect.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && digest_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // driver: bursts of words with random gaps, payload held while stalled
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    logic                   nxt_valid;
    sha256_pkg::sha256_in_t nxt_data;
    pend_word_t             head;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain && digest_expect.size() != 0)) begin
          head      = word_queue.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = head.item;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  task automatic flag_error(input sha256_pkg::sha256_out_t want,
                            input sha256_pkg::sha256_out_t got, input bit orphan);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      if (orphan)
        $display("unexpected digest transaction: word %h last %b",
                 got.digest_word, got.digest_last);
      else
        $display("digest mismatch: expected word %h last %b, got word %h last %b",
                 want.digest_word, want.digest_last, got.digest_word, got.digest_last);
    end
  endtask

  // monitor and receiver: checks digest words, stalls on its own pattern
  rx_mode_e stall_mode;
  int       mode_left;
  int       hold_left;
  bit       hold_done;
  int       digests_seen;

  always @(posedge clk_i or negedge rst_ni) begin : digest_monitor
    sha256_pkg::sha256_out_t want;
    logic                    nxt_stall;
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      stall_mode   = RX_FREE;
      mode_left    = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      digests_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_expect.size() == 0) begin
          flag_error(out_data, out_data, 1'b1);
        end else begin
          want = digest_expect.pop_front();
          if (out_data.digest_word !== want.digest_word ||
              out_data.digest_last !== want.digest_last)
            flag_error(want, out_data, 1'b0);
        end
        if (out_data.digest_last === 1'b1) digests_seen++;
      end
      // one long hold-off so the engine backs up into its input
      if (!hold_done && digests_seen >= 10) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        case (stall_mode)
          RX_FREE:  nxt_stall = 1'b0;
          RX_LIGHT: nxt_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY: nxt_stall = ($urandom_range(0, 3) != 0);
          default:  nxt_stall = ~out_stall;
        endcase
      end
      out_stall <= nxt_stall;
    end
  end

endmodule

### sha256_hash_engine.f
hdl/sha256_pkg.sv
hdl/sha256_core.sv
hdl/sha256_ctrl.sv
hdl/sha256_hash_engine.sv
tb/sha256_hash_engine_test.sv
